// ----- rtl/bilinear_crop_resize_normalize_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear crop, resize and normalize block
// Clocked on clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_CROP_RESIZE_NORMALIZE_DEFINES_SVH
`define BILINEAR_CROP_RESIZE_NORMALIZE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BRCN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define BRCN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/brcn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcn_pkg
// Shared constants, codes and types of the crop, resize and normalize block.
// ----------------------------------------------------------------------------
package brcn_pkg;

   localparam int MAX_SRC_WIDTH    = 512;
   localparam int MAX_SRC_HEIGHT   = 512;
   localparam int MAX_CHANNELS     = 4;
   localparam int MAX_DEST_SIDE    = 512;
   localparam int WEIGHT_FRAC_BITS = 8;

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
   localparam int XI_W        = $clog2(MAX_SRC_WIDTH);
   localparam int YI_W        = $clog2(MAX_SRC_HEIGHT);
   localparam int CIDX_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // fixed field widths
   localparam int MODE_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int COORD_W = 9;
   localparam int SIDE_W  = 10;
   localparam int CHAN_W  = 3;
   localparam int NORM_W  = 16;
   localparam int OUT_W   = 23;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_W  = 16;

   localparam int STEP_W  = SIDE_W + FRAC_W;
   localparam int POS_W   = COORD_W + STEP_W + 1;
   localparam int POSI_W  = POS_W - FRAC_W;
   localparam int STEP_CNT_W = $clog2(STEP_W + 1);

   localparam int WT_W    = WEIGHT_FRAC_BITS + 1;
   localparam int WPROD_W = 2 * WEIGHT_FRAC_BITS + 1;
   localparam int ACC_W   = 2 * WEIGHT_FRAC_BITS + BYTE_W;
   localparam int MEAN_SH = 2 * WEIGHT_FRAC_BITS - 8;
   localparam int NORM_SH = 2 * WEIGHT_FRAC_BITS + 2;
   localparam int PROD_W  = ACC_W + NORM_W;
   localparam int Q_W     = PROD_W - NORM_SH;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CROP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN_COUNT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_MEAN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_SCALE  = 3'd6;

   typedef struct packed {
      logic              start;
      logic [SIDE_W-1:0] num_x;
      logic [SIDE_W-1:0] num_y;
      logic [SIDE_W-1:0] den_x;
      logic [SIDE_W-1:0] den_y;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [STEP_W-1:0] quot_x;
      logic [STEP_W-1:0] quot_y;
   } div_rsp_type;

endpackage

// ----- rtl/bilinear_crop_resize_normalize.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_crop_resize_normalize
// Frame store with bilinear crop-resize sampling and mean/scale normalization.
// ----------------------------------------------------------------------------
// A load beat (req_tuser 0) writes one source byte into the frame store at the
// running load position; the position wraps at the end of the store. A crop
// beat (req_tuser 1) latches the crop origin and runs a restoring divider for
// both Q10.16 steps, one quotient bit per cycle. A pixel beat (req_tuser 2)
// forms the sample position, clamped neighbours, weights and base addresses,
// then per channel reads the four neighbours through the single read port of
// the frame store and normalizes the weighted sum. Results leave through an
// output register, so the next request is taken while the last channel still
// waits on rsp_tready. Mode 3 is dropped. The frame store is not cleared after
// reset; samples that read bytes never loaded are undefined.
// ----------------------------------------------------------------------------
module bilinear_crop_resize_normalize (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_byte[7:0], crop_x[16:8], crop_y[25:17], crop_w[35:26],
   // crop_h[45:36], dest_x[54:46], dest_y[63:55]
   input  logic [brcn_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [brcn_pkg::MODE_W-1:0]     req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // norm_value[22:0], zero pad [23]
   output logic [brcn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // channel_index[1:0]
   output logic [brcn_pkg::CIDX_W-1:0]     rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [brcn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [brcn_pkg::NORM_W-1:0]     csr_data
);
   import brcn_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_POS   = 4'd2;
   localparam logic [3:0] ST_IDX   = 4'd3;
   localparam logic [3:0] ST_ROW   = 4'd4;
   localparam logic [3:0] ST_ADDR  = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_LAST  = 4'd7;
   localparam logic [3:0] ST_NORM1 = 4'd8;
   localparam logic [3:0] ST_NORM2 = 4'd9;
   localparam logic [3:0] ST_EMIT  = 4'd10;

   // request fields
   logic [BYTE_W-1:0]  f_byte;
   logic [COORD_W-1:0] f_crop_x, f_crop_y, f_dest_x, f_dest_y;
   logic [SIDE_W-1:0]  f_crop_w, f_crop_h;

   assign f_byte   = req_tdata[7:0];
   assign f_crop_x = req_tdata[16:8];
   assign f_crop_y = req_tdata[25:17];
   assign f_crop_w = req_tdata[35:26];
   assign f_crop_h = req_tdata[45:36];
   assign f_dest_x = req_tdata[54:46];
   assign f_dest_y = req_tdata[63:55];

   // control state
   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  load_pos_ff, load_pos_in;
   logic [COORD_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [STEP_W-1:0]  stepx_ff, stepx_in, stepy_ff, stepy_in;
   logic [SIDE_W-1:0]  src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [CHAN_W-1:0]  chan_cnt_ff;
   logic [NORM_W-1:0]  mean_ff, scale_ff;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [POS_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic [XI_W-1:0]    x1_ff, x1_in, x2_ff, x2_in;
   logic [YI_W-1:0]    y1_ff, y1_in, y2_ff, y2_in;
   logic [WEIGHT_FRAC_BITS-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic [PIX_W-1:0]   row1_ff, row1_in, row2_ff, row2_in;
   logic [WPROD_W-1:0] wt_ff [4];
   logic [WPROD_W-1:0] wt_in [4];
   logic [ADDR_W-1:0]  base_ff [4];
   logic [ADDR_W-1:0]  base_in [4];
   logic [CIDX_W-1:0]  chan_ff, chan_in;
   logic [1:0]         k_ff, k_in, pend_k_ff, pend_k_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [ACC_W-1:0]   mag_ff, mag_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [OUT_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [CIDX_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic               rsp_last_ff, rsp_last_in;

   // effective sizes
   logic [SIDE_W-1:0]  w_eff, h_eff, w_last, h_last;
   logic [CHAN_W-1:0]  ch_eff;

   // frame store and divider hookup
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               req_fire;
   logic [POSI_W-1:0]  sxi, syi;
   logic [SIDE_W-1:0]  x1_w, y1_w, x1_inc, y1_inc;
   logic [WT_W-1:0]    owx, owy;
   logic [ACC_W:0]     diff;
   logic [Q_W-1:0]     q;
   logic [ACC_W-1:0]   mean_q;

   assign w_eff  = (src_w_ff == '0) ? SIDE_W'(1) :
                   (src_w_ff > SIDE_W'(MAX_SRC_WIDTH)) ? SIDE_W'(MAX_SRC_WIDTH) : src_w_ff;
   assign h_eff  = (src_h_ff == '0) ? SIDE_W'(1) :
                   (src_h_ff > SIDE_W'(MAX_SRC_HEIGHT)) ? SIDE_W'(MAX_SRC_HEIGHT) : src_h_ff;
   assign ch_eff = (chan_cnt_ff == '0) ? CHAN_W'(1) :
                   (chan_cnt_ff > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : chan_cnt_ff;
   assign w_last = w_eff - 1'b1;
   assign h_last = h_eff - 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // store writes happen straight from the accepted load beat
   assign wr_en = req_fire && (req_tuser == MODE_LOAD);

   assign div_req.start = req_fire && (req_tuser == MODE_CROP);
   assign div_req.num_x = f_crop_w;
   assign div_req.num_y = f_crop_h;
   assign div_req.den_x = dst_w_ff;
   assign div_req.den_y = dst_h_ff;

   // clamp integer parts to the last column and row
   assign sxi    = sx_ff[POS_W-1:FRAC_W];
   assign syi    = sy_ff[POS_W-1:FRAC_W];
   assign x1_w   = (sxi > POSI_W'(w_last)) ? w_last : SIDE_W'(sxi);
   assign y1_w   = (syi > POSI_W'(h_last)) ? h_last : SIDE_W'(syi);
   assign x1_inc = x1_w + 1'b1;
   assign y1_inc = y1_w + 1'b1;

   assign owx    = WT_W'(1 << WEIGHT_FRAC_BITS) - {1'b0, wx_ff};
   assign owy    = WT_W'(1 << WEIGHT_FRAC_BITS) - {1'b0, wy_ff};

   assign mean_q = ACC_W'(mean_ff) << MEAN_SH;
   assign diff   = {1'b0, acc_ff} - {1'b0, mean_q};
   assign q      = prod_ff[PROD_W-1:NORM_SH];

   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      stepx_in     = stepx_ff;
      stepy_in     = stepy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      row1_in      = row1_ff;
      row2_in      = row2_ff;
      for (int i = 0; i < 4; i++) begin
         wt_in[i]   = wt_ff[i];
         base_in[i] = base_ff[i];
      end
      chan_in      = chan_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      pend_k_in    = pend_k_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rd_en        = 1'b0;
      rd_addr      = base_ff[k_ff] + ADDR_W'(chan_ff);

      // fold in the byte read last cycle
      if (pend_ff) begin
         acc_in = acc_ff + ACC_W'(wt_ff[pend_k_ff]) * ACC_W'(rd_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  MODE_LOAD: begin
                     load_pos_in = load_pos_ff + 1'b1;
                  end
                  MODE_CROP: begin
                     ox_in    = f_crop_x;
                     oy_in    = f_crop_y;
                     state_in = ST_DIV;
                  end
                  MODE_PIXEL: begin
                     dx_in    = f_dest_x;
                     dy_in    = f_dest_y;
                     state_in = ST_POS;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               stepx_in = div_rsp.quot_x;
               stepy_in = div_rsp.quot_y;
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            sx_in    = POS_W'({ox_ff, {FRAC_W{1'b0}}}) + POS_W'(dx_ff) * POS_W'(stepx_ff);
            sy_in    = POS_W'({oy_ff, {FRAC_W{1'b0}}}) + POS_W'(dy_ff) * POS_W'(stepy_ff);
            state_in = ST_IDX;
         end
         ST_IDX: begin
            // weights come from the fraction before clamping
            wx_in    = sx_ff[FRAC_W-1 -: WEIGHT_FRAC_BITS];
            wy_in    = sy_ff[FRAC_W-1 -: WEIGHT_FRAC_BITS];
            x1_in    = XI_W'(x1_w);
            y1_in    = YI_W'(y1_w);
            x2_in    = (x1_inc > w_last) ? XI_W'(w_last) : XI_W'(x1_inc);
            y2_in    = (y1_inc > h_last) ? YI_W'(h_last) : YI_W'(y1_inc);
            state_in = ST_ROW;
         end
         ST_ROW: begin
            row1_in  = PIX_W'(y1_ff) * PIX_W'(w_eff);
            row2_in  = PIX_W'(y2_ff) * PIX_W'(w_eff);
            wt_in[0] = WPROD_W'(owx) * WPROD_W'(owy);
            wt_in[1] = WPROD_W'(wx_ff) * WPROD_W'(owy);
            wt_in[2] = WPROD_W'(owx) * WPROD_W'(wy_ff);
            wt_in[3] = WPROD_W'(wx_ff) * WPROD_W'(wy_ff);
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            base_in[0] = ADDR_W'(row1_ff + PIX_W'(x1_ff)) * ADDR_W'(ch_eff);
            base_in[1] = ADDR_W'(row1_ff + PIX_W'(x2_ff)) * ADDR_W'(ch_eff);
            base_in[2] = ADDR_W'(row2_ff + PIX_W'(x1_ff)) * ADDR_W'(ch_eff);
            base_in[3] = ADDR_W'(row2_ff + PIX_W'(x2_ff)) * ADDR_W'(ch_eff);
            chan_in    = '0;
            k_in       = '0;
            acc_in     = '0;
            state_in   = ST_READ;
         end
         ST_READ: begin
            // issue one neighbour read per cycle
            rd_en     = 1'b1;
            pend_in   = 1'b1;
            pend_k_in = k_ff;
            k_in      = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            pend_in  = 1'b0;
            state_in = ST_NORM1;
         end
         ST_NORM1: begin
            neg_in   = diff[ACC_W];
            mag_in   = diff[ACC_W] ? ACC_W'(-diff) : diff[ACC_W-1:0];
            state_in = ST_NORM2;
         end
         ST_NORM2: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(scale_ff);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = neg_ff ? OUT_W'(-{1'b0, q}) : OUT_W'({1'b0, q});
               rsp_chan_in  = chan_ff;
               rsp_last_in  = (CHAN_W'(chan_ff) == ch_eff - 1'b1);
               if (CHAN_W'(chan_ff) == ch_eff - 1'b1) begin
                  state_in = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_pos_ff  <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         stepx_ff     <= STEP_W'(1 << FRAC_W);
         stepy_ff     <= STEP_W'(1 << FRAC_W);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_w_ff     <= SIDE_W'(512);
         src_h_ff     <= SIDE_W'(512);
         dst_w_ff     <= SIDE_W'(112);
         dst_h_ff     <= SIDE_W'(112);
         chan_cnt_ff  <= CHAN_W'(1);
         mean_ff      <= NORM_W'(32640);
         scale_ff     <= NORM_W'(512);
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         stepx_ff     <= stepx_in;
         stepy_ff     <= stepy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SRC_WIDTH:   src_w_ff    <= csr_data[SIDE_W-1:0];
               CSR_SRC_HEIGHT:  src_h_ff    <= csr_data[SIDE_W-1:0];
               CSR_DEST_WIDTH:  dst_w_ff    <= csr_data[SIDE_W-1:0];
               CSR_DEST_HEIGHT: dst_h_ff    <= csr_data[SIDE_W-1:0];
               CSR_CHAN_COUNT:  chan_cnt_ff <= csr_data[CHAN_W-1:0];
               CSR_NORM_MEAN:   mean_ff     <= csr_data;
               CSR_NORM_SCALE:  scale_ff    <= csr_data;
               default: begin
                  // drop writes to unknown indexes
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      row1_ff     <= row1_in;
      row2_ff     <= row2_in;
      for (int i = 0; i < 4; i++) begin
         wt_ff[i]   <= wt_in[i];
         base_ff[i] <= base_in[i];
      end
      chan_ff     <= chan_in;
      k_ff        <= k_in;
      pend_k_ff   <= pend_k_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

   brcn_frame_mem u_frame_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_pos_ff),
      .wr_data (f_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brcn_step_div u_step_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_val_ff};
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/brcn_frame_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcn_frame_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brcn_frame_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [brcn_pkg::ADDR_W-1:0] wr_addr,
   input  logic [brcn_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [brcn_pkg::ADDR_W-1:0] rd_addr,
   output logic [brcn_pkg::BYTE_W-1:0] rd_data
);
   import brcn_pkg::*;

   logic [BYTE_W-1:0] mem_ff [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/brcn_step_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcn_step_div
// Restoring divider pair for the Q10.16 crop steps, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module brcn_step_div (
   input  logic                      clock,
   input  logic                      reset,
   input  brcn_pkg::div_req_type     div_req,
   output brcn_pkg::div_rsp_type     div_rsp
);
   import brcn_pkg::*;

   logic [STEP_W-1:0]     quo_ff [2];
   logic [STEP_W-1:0]     quo_in [2];
   logic [SIDE_W-1:0]     rem_ff [2];
   logic [SIDE_W-1:0]     rem_in [2];
   logic [SIDE_W-1:0]     den_ff [2];
   logic [SIDE_W-1:0]     den_in [2];
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [STEP_CNT_W-1:0] cnt_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [SIDE_W:0]       trial [2];
   logic [SIDE_W-1:0]     num [2];
   logic [SIDE_W-1:0]     den [2];

   assign num[0] = div_req.num_x;
   assign num[1] = div_req.num_y;
   assign den[0] = (div_req.den_x == '0) ? SIDE_W'(1) : div_req.den_x;
   assign den[1] = (div_req.den_y == '0) ? SIDE_W'(1) : div_req.den_y;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      for (int i = 0; i < 2; i++) begin
         quo_in[i] = quo_ff[i];
         rem_in[i] = rem_ff[i];
         den_in[i] = den_ff[i];
         trial[i]  = {rem_ff[i], quo_ff[i][STEP_W-1]};
      end
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         for (int i = 0; i < 2; i++) begin
            quo_in[i] = {num[i], {FRAC_W{1'b0}}};
            rem_in[i] = '0;
            den_in[i] = den[i];
         end
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, subtract when it fits
         for (int i = 0; i < 2; i++) begin
            if (trial[i] >= {1'b0, den_ff[i]}) begin
               rem_in[i] = SIDE_W'(trial[i] - {1'b0, den_ff[i]});
               quo_in[i] = {quo_ff[i][STEP_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][SIDE_W-1:0];
               quo_in[i] = {quo_ff[i][STEP_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(STEP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      for (int i = 0; i < 2; i++) begin
         quo_ff[i] <= quo_in[i];
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
      end
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quot_x = quo_ff[0];
   assign div_rsp.quot_y = quo_ff[1];

endmodule

// ----- rtl/brcn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcn_checker
// Port-level checks of the crop, resize and normalize block.
// ----------------------------------------------------------------------------
`include "bilinear_crop_resize_normalize_defines.svh"

module brcn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [brcn_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [brcn_pkg::MODE_W-1:0]      req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [brcn_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [brcn_pkg::CIDX_W-1:0]      rsp_tuser,
   input logic                             rsp_tlast,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [brcn_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [brcn_pkg::NORM_W-1:0]      csr_data
);
   import brcn_pkg::*;

   `BRCN_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result beat changed")

   `BRCN_ASSERT_NEXT(a_load_one_cycle,
      req_tvalid && req_tready && req_tuser == MODE_LOAD, req_tready,
      "load beat did not finish in one cycle")

   `BRCN_ASSERT_NOW(a_busy_mid_pixel, rsp_tvalid && !rsp_tlast, !req_tready,
      "request taken while a pixel still has channels to send")

   `BRCN_ASSERT_NOW(a_top_chan_last,
      rsp_tvalid && rsp_tuser == CIDX_W'(MAX_CHANNELS - 1), rsp_tlast,
      "highest channel not marked last")

endmodule

bind bilinear_crop_resize_normalize brcn_checker u_brcn_checker (.*);
